FILE: rtl/ata_pkg.sv
// shared types, constants and tables for the tilt angle unit
package ata_pkg;

  localparam int SampleW   = 16;
  localparam int OffW      = 12;
  localparam int DbW       = 8;
  localparam int SqW       = 2 * SampleW;
  localparam int RootW     = SampleW;
  localparam int Prescale  = 14;
  localparam int CwW       = RootW + Prescale + 3;
  localparam int AngW      = 24;
  localparam int Steps     = 23;
  localparam int SqSteps   = SqW / 2;
  localparam int SqCntW    = 5;

  localparam logic [1:0] REG_OFF_X = 2'd0;
  localparam logic [1:0] REG_OFF_Y = 2'd1;
  localparam logic [1:0] REG_OFF_Z = 2'd2;
  localparam logic [1:0] REG_DEAD  = 2'd3;

  typedef struct packed {
    logic               neg;
    logic               zero;
    logic [SampleW-1:0] mag;
  } xinfo_t;

  typedef struct packed {
    xinfo_t         xi;
    logic [SqW-1:0] rem;
    logic [SqW-1:0] root;
  } sq_t;

  typedef struct packed {
    logic                  neg;
    logic                  zero;
    logic signed [CwW-1:0] a;
    logic signed [CwW-1:0] b;
    logic signed [AngW-1:0] z;
  } cw_t;

  function automatic logic [AngW-1:0] atan_tab(input logic [SqCntW-1:0] i);
    logic [AngW-1:0] t;
    case (i)
      5'd0: t = 24'd2949337;  5'd1: t = 24'd1741095;  5'd2: t = 24'd919947;
      5'd3: t = 24'd466979;   5'd4: t = 24'd234396;   5'd5: t = 24'd117312;
      5'd6: t = 24'd58670;    5'd7: t = 24'd29337;    5'd8: t = 24'd14669;
      5'd9: t = 24'd7334;     5'd10: t = 24'd3667;    5'd11: t = 24'd1834;
      5'd12: t = 24'd917;     5'd13: t = 24'd458;     5'd14: t = 24'd229;
      5'd15: t = 24'd115;     5'd16: t = 24'd57;      5'd17: t = 24'd29;
      5'd18: t = 24'd14;      5'd19: t = 24'd7;       5'd20: t = 24'd4;
      5'd21: t = 24'd2;       5'd22: t = 24'd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/accel_tilt_angle_unit.sv
// tilt angle unit top level
// Pitch from one accelerometer sample: offset, saturate, deadband, then a row of
// 16 square root cells and 23 cordic cells. One word is taken every cycle unless
// the row is stalled; a word passes 42 register stages. The whole row moves
// only while the output register is free or being read, so stalls hold every
// cell.
module accel_tilt_angle_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_x, raw_y, raw_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // pitch_angle
);
  localparam int W = ata_pkg::SampleW;

  logic signed [ata_pkg::OffW-1:0] off_x_r, off_y_r, off_z_r;
  logic [ata_pkg::DbW-1:0]         dead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= 12'sd160;
      off_y_r <= 12'sd440;
      off_z_r <= 12'sd0;
      dead_r  <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ata_pkg::REG_OFF_X: off_x_r <= cfg_data;
        ata_pkg::REG_OFF_Y: off_y_r <= cfg_data;
        ata_pkg::REG_OFF_Z: off_z_r <= cfg_data;
        ata_pkg::REG_DEAD:  dead_r  <= cfg_data[ata_pkg::DbW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  function automatic logic signed [W-1:0] fix_axis(input logic signed [W-1:0] raw,
      input logic signed [ata_pkg::OffW-1:0] off, input logic [ata_pkg::DbW-1:0] db);
    logic signed [W:0] v;
    logic signed [W-1:0] s;
    logic [W-1:0] m;
    v = {raw[W-1], raw} - {{(W+1-ata_pkg::OffW){off[ata_pkg::OffW-1]}}, off};
    if (v > $signed({2'b00, {(W-1){1'b1}}}))       s = {1'b0, {(W-1){1'b1}}};
    else if (v < $signed({2'b11, {(W-1){1'b0}}}))  s = {1'b1, {(W-1){1'b0}}};
    else                                           s = v[W-1:0];
    m = s[W-1] ? -s : s;
    if (m <= {{(W-ata_pkg::DbW){1'b0}}, db}) s = '0;
    return s;
  endfunction

  // stage 0: correction and squares
  logic signed [W-1:0] cx, cy, cz;
  logic                v0_r;
  ata_pkg::xinfo_t     x0_r;
  logic [ata_pkg::SqW-1:0] sy_r, sz_r;

  always_comb begin
    cx = fix_axis(in_tdata[15:0], off_x_r, dead_r);
    cy = fix_axis(in_tdata[31:16], off_y_r, dead_r);
    cz = fix_axis(in_tdata[47:32], off_z_r, dead_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_tvalid;
    if (en) begin
      x0_r.neg  <= cx[W-1];
      x0_r.zero <= (cx == '0);
      x0_r.mag  <= cx[W-1] ? -cx : cx;
      sy_r      <= ata_pkg::SqW'(cy) * ata_pkg::SqW'(cy);
      sz_r      <= ata_pkg::SqW'(cz) * ata_pkg::SqW'(cz);
    end
  end

  // sum register, at most 2^31
  logic v1_r;
  ata_pkg::sq_t s1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v0_r;
    if (en) begin
      s1_r.xi   <= x0_r;
      s1_r.rem  <= sy_r + sz_r;
      s1_r.root <= '0;
    end
  end

  logic         sv [ata_pkg::SqSteps+1];
  ata_pkg::sq_t sd [ata_pkg::SqSteps+1];
  assign sv[0] = v1_r;
  assign sd[0] = s1_r;

  for (genvar g = 0; g < ata_pkg::SqSteps; g++) begin : g_sq
    ata_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(sv[g]), .d_i(sd[g]),
      .bit_i(ata_pkg::SqW'(1) << (ata_pkg::SqW - 2 - 2 * g)),
      .vld_o(sv[g+1]), .d_o(sd[g+1])
    );
  end

  ata_pkg::cw_t cd [ata_pkg::Steps+1];
  logic         cv [ata_pkg::Steps+1];
  ata_pkg::sq_t sl;
  assign sl = sd[ata_pkg::SqSteps];
  assign cv[0] = sv[ata_pkg::SqSteps];
  always_comb begin
    cd[0].neg  = sl.xi.neg;
    cd[0].zero = sl.xi.zero;
    cd[0].a    = ata_pkg::CwW'(sl.root[ata_pkg::RootW-1:0]) <<< ata_pkg::Prescale;
    cd[0].b    = ata_pkg::CwW'(sl.xi.mag) <<< ata_pkg::Prescale;
    cd[0].z    = '0;
  end

  for (genvar g = 0; g < ata_pkg::Steps; g++) begin : g_cr
    ata_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .idx(ata_pkg::SqCntW'(g)),
      .vld_i(cv[g]), .d_i(cd[g]),
      .vld_o(cv[g+1]), .d_o(cd[g+1])
    );
  end

  ata_pkg::cw_t        cf;
  logic signed [ata_pkg::AngW-1:0] rnd;
  logic signed [15:0]  res;
  logic                ov_r;
  logic [15:0]         od_r;
  assign cf  = cd[ata_pkg::Steps];
  assign rnd = (cf.z + 24'sd128) >>> 8;
  always_comb begin
    res = rnd[15:0];
    if (cf.neg) res = -res;
    if (cf.zero) res = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= cv[ata_pkg::Steps];
    if (en) od_r <= res;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule

FILE: rtl/ata_sqrt_cell.sv
// one restoring square root step per cell
module ata_sqrt_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  ata_pkg::sq_t             d_i,
  input  logic [ata_pkg::SqW-1:0]  bit_i,
  output logic                     vld_o,
  output ata_pkg::sq_t             d_o
);
  logic [ata_pkg::SqW-1:0] trial;
  ata_pkg::sq_t            nxt;
  logic                    vld_r;
  ata_pkg::sq_t            d_r;

  always_comb begin
    nxt   = d_i;
    trial = d_i.root + bit_i;
    if (d_i.rem >= trial) begin
      nxt.rem  = d_i.rem - trial;
      nxt.root = (d_i.root >> 1) + bit_i;
    end else begin
      nxt.root = d_i.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      d_r <= nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;
endmodule

FILE: rtl/ata_cordic_cell.sv
// one vectoring cordic rotation per cell
module ata_cordic_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [ata_pkg::SqCntW-1:0] idx,
  input  logic                       vld_i,
  input  ata_pkg::cw_t               d_i,
  output logic                       vld_o,
  output ata_pkg::cw_t               d_o
);
  ata_pkg::cw_t                     nxt;
  logic signed [ata_pkg::CwW-1:0]   da;
  logic signed [ata_pkg::CwW-1:0]   db;
  logic signed [ata_pkg::AngW-1:0]  t;
  logic                             vld_r;
  ata_pkg::cw_t                     d_r;

  always_comb begin
    nxt = d_i;
    da  = d_i.b >>> idx;
    db  = d_i.a >>> idx;
    t   = ata_pkg::atan_tab(idx);
    if (!d_i.b[ata_pkg::CwW-1]) begin
      nxt.a = d_i.a + da;
      nxt.b = d_i.b - db;
      nxt.z = d_i.z + t;
    end else begin
      nxt.a = d_i.a - da;
      nxt.b = d_i.b + db;
      nxt.z = d_i.z - t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      d_r <= nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;
endmodule

FILE: rtl/ata_checker.sv
// port level checks for the tilt angle unit
module ata_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready) else $error("ready low with free output");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready) else $error("input taken while stalled");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output changed while stalled");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= 16'sd23043 && $signed(out_tdata) >= -16'sd23043))
    else $error("angle out of range");
endmodule

bind accel_tilt_angle_unit ata_checker u_ata_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
